// ----- design/cmf1_pkg.sv -----
// Shared types, constants and helper functions of the confusion-matrix F1 scorer.
`timescale 1ns / 1ps
`default_nettype none

package cmf1_pkg;

    localparam int DEF_NUM_CLASSES = 16;
    localparam int DEF_COUNT_WIDTH = 32;

    // Internal sums saturate at this width.
    localparam int SUM_W  = 64;
    // Fraction bits of the Q0.16 scores; a score is one bit wider to hold 1.0.
    localparam int Q_FRAC  = 16;
    localparam int SCORE_W = Q_FRAC + 1;
    localparam logic [SCORE_W-1:0] Q_ONE = SCORE_W'(65536);

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_REC_WR,
        S_CLASS,
        S_WALK,
        S_DRAIN,
        S_PREP1,
        S_PREP2,
        S_NEXT,
        S_MICRO,
        S_MACRO,
        S_DIV_START,
        S_DIV_ITER,
        S_DIV_ROUND,
        S_DIV_DONE,
        S_OUT
    } cmf1_state_t;

    typedef enum logic [1:0] {
        SEL_CLASS,
        SEL_MICRO,
        SEL_MACRO
    } cmf1_div_sel_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/confusion_matrix_f1_scorer.sv -----
// Top level of the confusion-matrix F1 scorer: counter memory, sequencer and shared divider.
// A record beat takes a read, then a write of one counter; the block takes the next
// beat right after. A report beat walks the matrix one counter read per cycle: it skips each
// unseen class, walks the row and column of each seen class and divides for it if its TP is
// nonzero, then runs the micro and macro divides and a pass clearing the matrix.
// After reset the same clearing pass runs before s_tready rises; the seen-class flags
// clear at once. Reset is synchronous on aresetn low.
`timescale 1ns / 1ps
`default_nettype none

module confusion_matrix_f1_scorer
    import cmf1_pkg::*;
#(
    parameter int NUM_CLASSES = DEF_NUM_CLASSES,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    localparam int SEEN_W      = $clog2(NUM_CLASSES + 1),
    localparam int M_TDATA_W   = ((2 * SCORE_W + SEEN_W + 7) / 8) * 8
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    // s_tdata: true_class [3:0], predicted_class [7:4]
    input  wire  [7:0]           s_tdata,
    // s_tuser: action (0 record, 1 report)
    input  wire                  s_tuser,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    // m_tdata: micro_score [16:0], macro_score [33:17], seen_count above, zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: micro_undefined
    output logic                 m_tuser
);

    localparam int CLS_W   = $clog2(NUM_CLASSES);
    localparam int J_W     = CLS_W + 1;
    localparam int ADDR_W  = $clog2(NUM_CLASSES * NUM_CLASSES);
    localparam int F1S_W   = CLS_W + SCORE_W;
    localparam logic [ADDR_W-1:0]      LAST_ADDR = ADDR_W'(NUM_CLASSES * NUM_CLASSES - 1);
    localparam logic [J_W-1:0]         J_LAST    = J_W'(2 * NUM_CLASSES - 1);
    localparam logic [J_W-1:0]         J_ROW     = J_W'(NUM_CLASSES);
    localparam logic [CLS_W-1:0]       C_LAST    = CLS_W'(NUM_CLASSES - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Counter memory, one port for writes and one registered read port.
    logic [COUNT_WIDTH-1:0] mem [NUM_CLASSES*NUM_CLASSES];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [ADDR_W-1:0]      rd_addr, wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;
    logic                   mem_we;

    cmf1_state_t   state_reg, state_next;
    cmf1_div_sel_t div_sel_reg;

    logic [NUM_CLASSES-1:0] seen_reg;
    logic [ADDR_W-1:0]      clr_reg, rec_addr_reg;
    logic [CLS_W-1:0]       c_reg;
    logic [J_W-1:0]         j_reg;
    logic [SEEN_W-1:0]      seen_cnt_reg;

    // Per-class and pooled sums.
    logic [SUM_W-1:0] tp_reg, fp_reg, fn_reg, diag_reg, total_reg;
    logic [SUM_W-1:0] two_tp_reg, fpfn_reg, tpfn_reg;
    logic [F1S_W-1:0] f1_sum_reg;

    // Tag of the counter read issued last cycle.
    logic tag_valid_reg, tag_diag_reg, tag_fn_reg;

    // Shared divider.
    logic [SUM_W-1:0]   div_num_reg, div_den_reg, div_r_reg;
    logic [SCORE_W-1:0] div_q_reg;
    logic [3:0]         div_it_reg;
    logic [SUM_W-1:0]   div_gap;

    logic [SCORE_W-1:0] micro_reg, macro_reg;
    logic               undef_reg;

    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic                   m_tuser_reg;

    logic                   accept, in_range, out_free;
    logic [CLS_W-1:0]       in_t, in_p, walk_k;
    logic                   walk_row;

    assign accept   = s_tvalid && s_tready;
    assign in_range = (s_tdata[3:0] < NUM_CLASSES) && (s_tdata[7:4] < NUM_CLASSES);
    assign in_t     = CLS_W'(s_tdata[3:0]);
    assign in_p     = CLS_W'(s_tdata[7:4]);
    assign walk_row = (j_reg < J_ROW);
    assign walk_k   = walk_row ? j_reg[CLS_W-1:0] : CLS_W'(j_reg - J_ROW);
    assign div_gap  = div_den_reg - div_r_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:     if (clr_reg == LAST_ADDR) state_next = S_IDLE;
            S_IDLE: begin
                if (accept && s_tuser == ACT_REPORT) state_next = S_CLASS;
                else if (accept && in_range)        state_next = S_REC_WR;
            end
            S_REC_WR:    state_next = S_IDLE;
            S_CLASS:     state_next = seen_reg[c_reg] ? S_WALK : S_NEXT;
            S_WALK:      if (j_reg == J_LAST) state_next = S_DRAIN;
            S_DRAIN:     state_next = S_PREP1;
            S_PREP1:     state_next = S_PREP2;
            S_PREP2:     state_next = (tp_reg != '0) ? S_DIV_START : S_NEXT;
            S_NEXT:      state_next = (c_reg == C_LAST) ? S_MICRO : S_CLASS;
            S_MICRO:     state_next = (total_reg == '0) ? S_MACRO : S_DIV_START;
            S_MACRO:     state_next = (seen_cnt_reg == '0) ? S_OUT : S_DIV_START;
            S_DIV_START: begin
                if (div_den_reg == '0 || div_num_reg == '0 || div_num_reg >= div_den_reg)
                    state_next = S_DIV_DONE;
                else
                    state_next = S_DIV_ITER;
            end
            S_DIV_ITER:  if (div_it_reg == 4'(Q_FRAC - 1)) state_next = S_DIV_ROUND;
            S_DIV_ROUND: state_next = S_DIV_DONE;
            S_DIV_DONE: begin
                unique case (div_sel_reg)
                    SEL_CLASS: state_next = S_NEXT;
                    SEL_MICRO: state_next = S_MACRO;
                    default:   state_next = S_OUT;
                endcase
            end
            S_OUT:       if (out_free) state_next = S_CLEAR;
            default:     state_next = S_IDLE;
        endcase
    end

    // Handshake and memory port controls.
    always_comb begin
        s_tready = 1'b0;
        mem_we   = 1'b0;
        wr_addr  = clr_reg;
        wr_data  = '0;
        rd_addr  = ADDR_W'(in_t) * ADDR_W'(NUM_CLASSES) + ADDR_W'(in_p);
        unique case (state_reg)
            S_IDLE:   s_tready = 1'b1;
            S_CLEAR:  mem_we   = 1'b1;
            S_REC_WR: begin
                mem_we  = 1'b1;
                wr_addr = rec_addr_reg;
                wr_data = (rd_data_reg == COUNT_MAX) ? rd_data_reg
                                                     : rd_data_reg + COUNT_WIDTH'(1);
            end
            S_WALK: begin
                if (walk_row)
                    rd_addr = ADDR_W'(c_reg) * ADDR_W'(NUM_CLASSES) + ADDR_W'(walk_k);
                else
                    rd_addr = ADDR_W'(walk_k) * ADDR_W'(NUM_CLASSES) + ADDR_W'(c_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            seen_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            tag_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;

            // The result beat is loaded in S_OUT and dropped once taken.
            if (state_reg == S_OUT && out_free) m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)  m_tvalid_reg <= 1'b0;

            // The diagonal is read once, in the row half.
            tag_valid_reg <= (state_reg == S_WALK) && seen_reg[walk_k]
                             && (walk_row || walk_k != c_reg);

            // Fold the counter read last cycle into TP, FN or FP.
            if (tag_valid_reg) begin
                if (tag_diag_reg)    tp_reg <= SUM_W'(rd_data_reg);
                else if (tag_fn_reg) fn_reg <= sat_add(fn_reg, SUM_W'(rd_data_reg));
                else                 fp_reg <= sat_add(fp_reg, SUM_W'(rd_data_reg));
            end

            unique case (state_reg)
                S_CLEAR: clr_reg <= clr_reg + ADDR_W'(1);
                S_IDLE: begin
                    if (accept && s_tuser == ACT_REPORT) begin
                        c_reg        <= '0;
                        seen_cnt_reg <= '0;
                        diag_reg     <= '0;
                        total_reg    <= '0;
                        f1_sum_reg   <= '0;
                    end else if (accept && in_range) begin
                        seen_reg[in_t] <= 1'b1;
                        rec_addr_reg   <= rd_addr;
                    end
                end
                S_CLASS: begin
                    if (seen_reg[c_reg]) begin
                        tp_reg       <= '0;
                        fp_reg       <= '0;
                        fn_reg       <= '0;
                        j_reg        <= '0;
                        seen_cnt_reg <= seen_cnt_reg + SEEN_W'(1);
                    end
                end
                S_WALK: begin
                    tag_diag_reg  <= walk_k == c_reg;
                    tag_fn_reg    <= walk_row;
                    j_reg         <= j_reg + J_W'(1);
                end
                S_PREP1: begin
                    two_tp_reg <= sat_add(tp_reg, tp_reg);
                    fpfn_reg   <= sat_add(fp_reg, fn_reg);
                    tpfn_reg   <= sat_add(tp_reg, fn_reg);
                    diag_reg   <= sat_add(diag_reg, tp_reg);
                end
                S_PREP2: begin
                    total_reg   <= sat_add(total_reg, tpfn_reg);
                    div_num_reg <= two_tp_reg;
                    div_den_reg <= sat_add(two_tp_reg, fpfn_reg);
                    div_sel_reg <= SEL_CLASS;
                end
                S_NEXT: if (c_reg != C_LAST) c_reg <= c_reg + CLS_W'(1);
                S_MICRO: begin
                    undef_reg   <= (total_reg == '0);
                    micro_reg   <= '0;
                    div_num_reg <= diag_reg;
                    div_den_reg <= total_reg;
                    div_sel_reg <= SEL_MICRO;
                end
                S_MACRO: begin
                    macro_reg   <= '0;
                    div_num_reg <= SUM_W'(f1_sum_reg);
                    div_den_reg <= SUM_W'(seen_cnt_reg) << Q_FRAC;
                    div_sel_reg <= SEL_MACRO;
                end
                S_DIV_START: begin
                    div_r_reg  <= div_num_reg;
                    div_it_reg <= '0;
                    if (div_den_reg == '0 || div_num_reg == '0) div_q_reg <= '0;
                    else if (div_num_reg >= div_den_reg)        div_q_reg <= Q_ONE;
                    else                                        div_q_reg <= '0;
                end
                S_DIV_ITER: begin
                    // One quotient bit a cycle, remainder kept below the divisor.
                    if (div_r_reg >= div_gap) begin
                        div_r_reg <= div_r_reg - div_gap;
                        div_q_reg <= {div_q_reg[SCORE_W-2:0], 1'b1};
                    end else begin
                        div_r_reg <= div_r_reg + div_r_reg;
                        div_q_reg <= {div_q_reg[SCORE_W-2:0], 1'b0};
                    end
                    div_it_reg <= div_it_reg + 4'd1;
                end
                S_DIV_ROUND: if (div_r_reg >= div_gap) div_q_reg <= div_q_reg + SCORE_W'(1);
                S_DIV_DONE: begin
                    unique case (div_sel_reg)
                        SEL_CLASS: f1_sum_reg <= f1_sum_reg + F1S_W'(div_q_reg);
                        SEL_MICRO: micro_reg  <= div_q_reg;
                        default:   macro_reg  <= div_q_reg;
                    endcase
                end
                S_OUT: begin
                    if (out_free) begin
                        m_tdata_reg  <= M_TDATA_W'({seen_cnt_reg, macro_reg, micro_reg});
                        m_tuser_reg  <= undef_reg;
                        clr_reg      <= '0;
                        seen_reg     <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/cmf1_checker.sv -----
// Port-level assertions for the confusion-matrix F1 scorer and their bind.
`timescale 1ns / 1ps
`default_nettype none

module cmf1_checker #(
    parameter int M_TDATA_W = 40
) (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_tvalid,
    input wire                 s_tready,
    input wire                 m_tvalid,
    input wire                 m_tready,
    input wire [M_TDATA_W-1:0] m_tdata,
    input wire                 m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    a_micro_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[16:0] <= 17'd65536)
        else $error("micro score above one");

    a_macro_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[33:17] <= 17'd65536)
        else $error("macro score above one");

    a_undef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[16:0] == 17'd0)
        else $error("undefined micro score is not zero");

    a_ready_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken in back-to-back cycles");

endmodule

bind confusion_matrix_f1_scorer cmf1_checker #(.M_TDATA_W(M_TDATA_W)) u_cmf1_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- bench/tb_confusion_matrix_f1_scorer.sv -----
// Self-checking testbench of the confusion-matrix F1 scorer: directed and random beats.
`timescale 1ns / 1ps

module tb_confusion_matrix_f1_scorer;
    import cmf1_pkg::*;

    localparam int NCLS = 16;
    localparam int SEEN_W = $clog2(NCLS + 1);
    localparam int M_W = ((2 * SCORE_W + SEEN_W + 7) / 8) * 8;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [SCORE_W-1:0] micro;
        logic [SCORE_W-1:0] macro;
        logic [SEEN_W-1:0]  seen;
        logic               undef;
    } score_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic [7:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tready = 1'b0;
    wire s_tready;
    wire m_tvalid;
    wire [M_W-1:0] m_tdata;
    wire m_tuser;

    confusion_matrix_f1_scorer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // Mirror of the matrix and the seen-class flags.
    longint unsigned counts [NCLS][NCLS];
    bit              seen_flag [NCLS];
    score_t          pending_scores [$];
    int              errors = 0;
    int              reports_seen = 0;
    int              beats_sent = 0;
    bit              hold_off = 1'b0;
    longint          cycles = 0;

    function automatic longint unsigned sadd(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
    endfunction

    // Q0.16 quotient, round to nearest with ties up.
    function automatic logic [SCORE_W-1:0] q16_div(longint unsigned num, longint unsigned den);
        logic [SCORE_W-1:0] q;
        longint unsigned r;
        if (den == 0 || num == 0) return '0;
        if (num >= den) return Q_ONE;
        q = '0;
        r = num;
        for (int i = 0; i < Q_FRAC; i++) begin
            if (r >= den - r) begin
                r = r - (den - r);
                q = {q[SCORE_W-2:0], 1'b1};
            end else begin
                r = r + r;
                q = {q[SCORE_W-2:0], 1'b0};
            end
        end
        if (r >= den - r) q++;
        return q;
    endfunction

    function automatic void clear_matrix();
        for (int a = 0; a < NCLS; a++) begin
            seen_flag[a] = 0;
            for (int b = 0; b < NCLS; b++) counts[a][b] = 0;
        end
    endfunction

    // Updates the mirror for one beat; a report pushes its expected scores.
    function automatic void predict_beat(logic act, logic [3:0] tc, logic [3:0] pc);
        score_t r;
        longint unsigned tp, fp, fn, diag, total, f1_sum;
        int nseen;
        if (act == ACT_RECORD) begin
            if (counts[tc][pc] < 64'hFFFF_FFFF) counts[tc][pc]++;
            seen_flag[tc] = 1;
            return;
        end
        diag = 0; total = 0; f1_sum = 0; nseen = 0;
        for (int c = 0; c < NCLS; c++) begin
            if (!seen_flag[c]) continue;
            nseen++;
            tp = counts[c][c]; fp = 0; fn = 0;
            for (int k = 0; k < NCLS; k++) begin
                if (k == c || !seen_flag[k]) continue;
                fp = sadd(fp, counts[k][c]);
                fn = sadd(fn, counts[c][k]);
            end
            diag = sadd(diag, tp);
            total = sadd(total, sadd(tp, fn));
            if (tp != 0) f1_sum += q16_div(sadd(tp, tp), sadd(sadd(tp, tp), sadd(fp, fn)));
        end
        r.undef = (total == 0);
        r.micro = r.undef ? '0 : q16_div(diag, total);
        r.macro = (nseen == 0) ? '0 : q16_div(f1_sum, longint'(nseen) * 65536);
        r.seen = SEEN_W'(nseen);
        pending_scores.push_back(r);
        clear_matrix();
    endfunction

    // Sends one beat, with a random gap before it at times.
    task automatic send_beat(logic act, logic [3:0] tc, logic [3:0] pc, bit gaps = 1);
        if (gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {pc, tc};
        do @(posedge aclk); while (!s_tready);
        predict_beat(act, tc, pc);
        beats_sent++;
    endtask

    task automatic idle_sender();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        idle_sender();
        while (pending_scores.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // Receiver: stall pattern of its own, and a long hold-off when asked.
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else if (hold_off) m_tready <= 1'b0;
        else m_tready <= ((cycles / 64) % 4 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    // Checks each accepted result beat against the oldest expectation.
    always @(posedge aclk) begin
        score_t want;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_scores.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                want = pending_scores.pop_front();
                reports_seen++;
                if (m_tdata[SCORE_W-1:0] !== want.micro) begin
                    $error("micro_score expected %0d got %0d", want.micro, m_tdata[SCORE_W-1:0]);
                    errors++;
                end
                if (m_tdata[2*SCORE_W-1:SCORE_W] !== want.macro) begin
                    $error("macro_score expected %0d got %0d", want.macro,
                           m_tdata[2*SCORE_W-1:SCORE_W]);
                    errors++;
                end
                if (m_tdata[2*SCORE_W+SEEN_W-1:2*SCORE_W] !== want.seen) begin
                    $error("seen_count expected %0d got %0d", want.seen,
                           m_tdata[2*SCORE_W+SEEN_W-1:2*SCORE_W]);
                    errors++;
                end
                if (m_tuser !== want.undef) begin
                    $error("micro_undefined expected %0d got %0d", want.undef, m_tuser);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("[confusion_matrix_f1_scorer] ERROR");
            $finish;
        end
    end

    task automatic test_empty_and_edges();
        send_beat(ACT_REPORT, 4'd0, 4'd0);          // nothing seen at all
        send_beat(ACT_RECORD, 4'd0, 4'd0);
        send_beat(ACT_RECORD, 4'd15, 4'd15);
        send_beat(ACT_RECORD, 4'd15, 4'd0);
        send_beat(ACT_REPORT, 4'd15, 4'd15);
        // Prediction of an unseen class is dropped, so the micro total is empty.
        send_beat(ACT_RECORD, 4'd3, 4'd9);
        send_beat(ACT_REPORT, 4'd0, 4'd0);
        // Total nonzero but no true positives anywhere.
        send_beat(ACT_RECORD, 4'd1, 4'd2);
        send_beat(ACT_RECORD, 4'd2, 4'd1);
        send_beat(ACT_REPORT, 4'd0, 4'd0);
        // Every class seen, every one right.
        for (int c = 0; c < NCLS; c++) send_beat(ACT_RECORD, 4'(c), 4'(c));
        send_beat(ACT_REPORT, 4'hA, 4'h5);
        wait_drained();
    endtask

    // Well-formed sessions: records on a random class subset, then a report.
    task automatic test_random_sessions(int n_beats);
        int sent, len, ncls, base;
        sent = 0;
        while (sent < n_beats) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 25);
            ncls = $urandom_range(1, NCLS);
            base = $urandom_range(0, NCLS - 1);
            for (int i = 0; i < len; i++) begin
                logic [3:0] tc, pc;
                tc = 4'((base + $urandom_range(0, ncls - 1)) % NCLS);
                case ($urandom_range(0, 3))
                    0: pc = 4'($urandom);
                    1: pc = 4'((base + $urandom_range(0, ncls - 1)) % NCLS);
                    default: pc = tc;
                endcase
                send_beat(ACT_RECORD, tc, pc);
            end
            send_beat(ACT_REPORT, 4'($urandom), 4'($urandom));
            sent += len + 1;
        end
        wait_drained();
    endtask

    // Receiver holds off for a fixed stretch while reports pile up, so the input stalls.
    task automatic test_backpressure();
        fork
            begin
                hold_off <= 1'b1;
                repeat (3000) @(posedge aclk);
                hold_off <= 1'b0;
            end
            begin
                for (int i = 0; i < 6; i++) begin
                    send_beat(ACT_RECORD, 4'($urandom), 4'($urandom), 0);
                    send_beat(ACT_REPORT, 4'd0, 4'd0, 0);
                end
                idle_sender();
            end
        join
        wait_drained();
    endtask

    initial begin
        clear_matrix();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_and_edges();
        test_backpressure();
        test_random_sessions(1520);
        repeat (2000) @(posedge aclk);
        $display("Sent %0d beats; checked %0d score reports, incl. empty, saturating-free",
                 beats_sent, reports_seen);
        $display("edge, unseen-prediction and stalled-output cases.");
        if (errors == 0 && pending_scores.size() == 0) begin
            $display("[confusion_matrix_f1_scorer] OK");
        end else begin
            $display("[confusion_matrix_f1_scorer] ERROR");
        end
        $finish;
    end
endmodule
